>>> hdl/button_gesture_classifier_assert.svh
// ----------------------------------------------------------------------------
// button gesture classifier assertion macros
// shorthand for the concurrent checks used by the port checker
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_CLASSIFIER_ASSERT_SVH
`define BUTTON_GESTURE_CLASSIFIER_ASSERT_SVH

// same-cycle implication, masked while reset is high
`define BGC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("button gesture classifier check failed");

// next-cycle implication, masked while reset is high
`define BGC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("button gesture classifier check failed");

// next-cycle implication that also holds across reset
`define BGC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("button gesture classifier check failed");

`endif

>>> hdl/bgc_pkg.sv
// ----------------------------------------------------------------------------
// bgc_pkg
// types and constants of the button gesture classifier
// ----------------------------------------------------------------------------
`default_nettype none

package bgc_pkg;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_CLICK     = 3'd1,
      EV_DOUBLE    = 3'd2,
      EV_HOLD      = 3'd3,
      EV_VERY_LONG = 3'd4
   } event_type;

   typedef enum logic [1:0] {
      CSR_DEBOUNCE     = 2'd0,
      CSR_HOLD         = 2'd1,
      CSR_VERY_LONG    = 2'd2,
      CSR_DOUBLE_CLICK = 2'd3
   } csr_index_type;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned DEB_W  = 8;
   localparam int unsigned DUR_W  = 16;
   localparam int unsigned CSR_W  = 16;

   localparam logic [DEB_W-1:0] DEBOUNCE_RST     = 8'd20;
   localparam logic [DUR_W-1:0] HOLD_RST         = 16'd800;
   localparam logic [DUR_W-1:0] VERY_LONG_RST    = 16'd3000;
   localparam logic [DUR_W-1:0] DOUBLE_CLICK_RST = 16'd300;

   // click counter wraps at this count and turns into a double click
   localparam logic [1:0] DOUBLE_COUNT = 2'd2;

endpackage

`default_nettype wire

>>> hdl/button_gesture_classifier.sv
// ----------------------------------------------------------------------------
// button_gesture_classifier
// click / double click / hold / very long press detector on millisecond ticks
// ----------------------------------------------------------------------------
// Every transaction on the req channel is one millisecond tick: the sampled
// active-low button level and a clear request. Every tick yields exactly one
// rsp transaction with an event code (0 none, 1 click, 2 double click,
// 3 hold, 4 very long). One tick is taken per clock cycle when the rsp side
// does not stall. A tick passes the input register, then the single
// state-update stage that writes the result register. That stage sets the
// rate, deciding a tick against stored time stamps with a few 32-bit
// subtract-and-compare paths. The user must write configuration registers via
// the csr port while no tick is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module button_gesture_classifier
   import bgc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic             req_pin_level,
   input  wire logic             req_clear_events,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [2:0]            rsp_event_code,
   input  wire logic             csr_wen,
   input  wire logic [1:0]       csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata
);

   // configuration
   logic [DEB_W-1:0] debounce_ff;
   logic [DUR_W-1:0] hold_ff;
   logic [DUR_W-1:0] very_long_ff;
   logic [DUR_W-1:0] double_click_ff;

   // input register
   logic in_valid_ff;
   logic in_pin_ff;
   logic in_clear_ff;

   // result register
   logic      rsp_valid_ff, rsp_valid_in;
   event_type rsp_event_ff, rsp_event_in;

   // tick state
   logic [TIME_W-1:0] time_now_ff, time_now_in;
   logic              accepted_ff, accepted_in;
   logic [DEB_W-1:0]  debounce_left_ff, debounce_left_in;
   logic [TIME_W-1:0] change_time_ff, change_time_in;
   logic [TIME_W-1:0] press_time_ff, press_time_in;
   logic [TIME_W-1:0] release_time_ff, release_time_in;
   logic [1:0]        click_count_ff, click_count_in;
   logic              hold_rep_ff, hold_rep_in;
   logic              very_long_rep_ff, very_long_rep_in;
   logic              click_pending_ff, click_pending_in;

   logic advance;
   logic step;

   // combinational work signals
   logic              go;
   logic              take;
   logic              take_press;
   logic              take_release;
   logic [TIME_W-1:0] tick_time;
   logic [TIME_W-1:0] since_press;
   logic [TIME_W-1:0] since_release;
   logic [TIME_W-1:0] held;
   logic [DEB_W-1:0]  debounce_dec;
   logic [1:0]        count_inc;
   logic [1:0]        count_clr;
   logic              hold_clr;
   logic              very_long_clr;
   logic              pending_clr;
   event_type         ev;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_code = rsp_event_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff     <= DEBOUNCE_RST;
         hold_ff         <= HOLD_RST;
         very_long_ff    <= VERY_LONG_RST;
         double_click_ff <= DOUBLE_CLICK_RST;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEBOUNCE:     debounce_ff     <= csr_wdata[DEB_W-1:0];
            CSR_HOLD:         hold_ff         <= csr_wdata[DUR_W-1:0];
            CSR_VERY_LONG:    very_long_ff    <= csr_wdata[DUR_W-1:0];
            CSR_DOUBLE_CLICK: double_click_ff <= csr_wdata[DUR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         in_pin_ff   <= req_pin_level;
         in_clear_ff <= req_clear_events;
      end
   end

   always_comb begin
      // clear request is applied before anything else in the tick
      count_clr     = in_clear_ff ? 2'd0 : click_count_ff;
      hold_clr      = in_clear_ff ? 1'b0 : hold_rep_ff;
      very_long_clr = in_clear_ff ? 1'b0 : very_long_rep_ff;
      pending_clr   = in_clear_ff ? 1'b0 : click_pending_ff;

      debounce_dec     = debounce_left_ff - 1'b1;
      debounce_left_in = debounce_left_ff;
      change_time_in   = change_time_ff;
      tick_time        = time_now_ff;
      go               = 1'b1;
      take             = 1'b0;

      if (debounce_left_ff != '0) begin
         debounce_left_in = debounce_dec;
         tick_time        = change_time_ff;
         if (debounce_dec != '0 || in_pin_ff == accepted_ff) begin
            go = 1'b0;
         end else begin
            take = 1'b1;
         end
      end else if (in_pin_ff != accepted_ff) begin
         if (debounce_ff == '0) begin
            take = 1'b1;
         end else begin
            change_time_in   = time_now_ff;
            debounce_left_in = debounce_ff;
            go               = 1'b0;
         end
      end

      take_press   = take && !in_pin_ff;
      take_release = take && in_pin_ff;
      since_press  = tick_time - press_time_ff;
      since_release = tick_time - release_time_ff;
      count_inc    = count_clr + 2'd1;

      accepted_in      = take ? in_pin_ff : accepted_ff;
      press_time_in    = take_press ? tick_time : press_time_ff;
      release_time_in  = take_release ? tick_time : release_time_ff;
      hold_rep_in      = take_press ? 1'b0 : hold_clr;
      very_long_rep_in = take_press ? 1'b0 : very_long_clr;
      click_count_in   = count_clr;
      click_pending_in = pending_clr;
      ev               = EV_NONE;

      // short press counts as a click, the second one is a double click
      if (take_release && since_press < {{(TIME_W-DUR_W){1'b0}}, hold_ff}) begin
         if (count_inc == DOUBLE_COUNT) begin
            click_count_in   = 2'd0;
            click_pending_in = 1'b0;
            ev               = EV_DOUBLE;
         end else begin
            click_count_in   = count_inc;
            click_pending_in = 1'b1;
         end
      end

      held = take_press ? '0 : since_press;

      if (go) begin
         if (!accepted_in) begin
            if (!very_long_rep_in && held >= {{(TIME_W-DUR_W){1'b0}}, very_long_ff}) begin
               very_long_rep_in = 1'b1;
               hold_rep_in      = 1'b1;
               click_count_in   = 2'd0;
               ev               = EV_VERY_LONG;
            end else if (!hold_rep_in && held >= {{(TIME_W-DUR_W){1'b0}}, hold_ff}) begin
               hold_rep_in    = 1'b1;
               click_count_in = 2'd0;
               ev             = EV_HOLD;
            end
         end
         // a release in this tick leaves zero time since release
         if (ev == EV_NONE && click_pending_in && !take_release &&
             since_release > {{(TIME_W-DUR_W){1'b0}}, double_click_ff}) begin
            ev               = EV_CLICK;
            click_pending_in = 1'b0;
            click_count_in   = 2'd0;
         end
      end

      time_now_in  = time_now_ff + 1'b1;
      rsp_valid_in = step ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_event_in = ev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         time_now_ff      <= '0;
         accepted_ff      <= 1'b1;
         debounce_left_ff <= '0;
         change_time_ff   <= '0;
         press_time_ff    <= '0;
         release_time_ff  <= '0;
         click_count_ff   <= '0;
         hold_rep_ff      <= 1'b0;
         very_long_rep_ff <= 1'b0;
         click_pending_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            time_now_ff      <= time_now_in;
            accepted_ff      <= accepted_in;
            debounce_left_ff <= debounce_left_in;
            change_time_ff   <= change_time_in;
            press_time_ff    <= press_time_in;
            release_time_ff  <= release_time_in;
            click_count_ff   <= click_count_in;
            hold_rep_ff      <= hold_rep_in;
            very_long_rep_ff <= very_long_rep_in;
            click_pending_ff <= click_pending_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_event_ff <= rsp_event_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/bgc_checker.sv
// ----------------------------------------------------------------------------
// bgc_checker
// port-level checks of the button gesture classifier, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_gesture_classifier_assert.svh"

module bgc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        req_pin_level,
   input wire logic        req_clear_events,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [2:0]  rsp_event_code,
   input wire logic        csr_wen,
   input wire logic [1:0]  csr_index,
   input wire logic [15:0] csr_wdata
);

   logic unused_inputs;
   assign unused_inputs = req_valid ^ req_pin_level ^ req_clear_events ^ csr_wen ^
                          (^csr_index) ^ (^csr_wdata);

   // a stalled result holds its value
   `BGC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_event_code))

   // input side only backs up when the result register is full and stalled
   `BGC_ASSERT_IMPLY(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // reset empties both stages
   `BGC_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && !req_stall)

   // a free output side drains the pending result; with no new tick the input side is not stalled in the next cycle
   `BGC_ASSERT_NEXT(a_drain, clock, reset, rsp_valid && !rsp_stall && !req_stall && !req_valid, !req_stall)

endmodule

bind button_gesture_classifier bgc_checker u_bgc_checker (.*);

`default_nettype wire

>>> test/button_gesture_classifier_tb.sv
// ----------------------------------------------------------------------------
// button_gesture_classifier_tb
// self-checking bench for the button gesture classifier
// ----------------------------------------------------------------------------
// Ticks go in on the req channel, one per transaction. An in-bench model of
// the debounce and gesture logic predicts the event code of each tick, and
// every rsp transaction is compared in order against it. Directed tests
// cover reset defaults, clears, bounce rejection, double click, lone click,
// hold and very long presses, zero debounce and the register extremes. A
// random part then runs press and release sequences with chatter and noise
// under a series of register settings, with random idle bursts on both
// sides in some phases, never in the last.
// ----------------------------------------------------------------------------
module button_gesture_classifier_tb
   import bgc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned RANDOM_PHASES  = 8;

   logic             clock;
   logic             reset            = 1'b1;
   logic             req_valid        = 1'b0;
   logic             req_stall;
   logic             req_pin_level    = 1'b1;
   logic             req_clear_events = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall        = 1'b0;
   logic [2:0]       rsp_event_code;
   logic             csr_wen          = 1'b0;
   logic [1:0]       csr_index        = CSR_DEBOUNCE;
   logic [CSR_W-1:0] csr_wdata        = '0;

   button_gesture_classifier dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pin_level    (req_pin_level),
      .req_clear_events (req_clear_events),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_code   (rsp_event_code),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // gesture model state and its copy of the registers
   logic [DEB_W-1:0]  cfg_debounce;
   logic [DUR_W-1:0]  cfg_hold;
   logic [DUR_W-1:0]  cfg_vlong;
   logic [DUR_W-1:0]  cfg_dclick;
   logic [TIME_W-1:0] tick_count;
   logic [TIME_W-1:0] change_at;
   logic [TIME_W-1:0] press_at;
   logic [TIME_W-1:0] release_at;
   logic              acc_level;
   logic [DEB_W-1:0]  deb_left;
   logic [1:0]        clicks;
   logic              hold_seen;
   logic              vlong_seen;
   logic              click_waiting;

   event_type   expected_events[$];
   int unsigned errors;
   int unsigned ticks_sent;
   int unsigned settings_used;
   int unsigned seen_count[5];
   int unsigned stall_left;
   logic        gaps_on;
   logic        random_clears;

   task automatic reset_model;
      cfg_debounce  = DEBOUNCE_RST;
      cfg_hold      = HOLD_RST;
      cfg_vlong     = VERY_LONG_RST;
      cfg_dclick    = DOUBLE_CLICK_RST;
      tick_count    = '0;
      change_at     = '0;
      press_at      = '0;
      release_at    = '0;
      acc_level     = 1'b1;
      deb_left      = '0;
      clicks        = '0;
      hold_seen     = 1'b0;
      vlong_seen    = 1'b0;
      click_waiting = 1'b0;
   endtask

   // commit a debounced level; a release may complete a double click
   function automatic event_type take_level(input logic lvl, input logic [TIME_W-1:0] t_at);
      event_type         ev;
      logic [TIME_W-1:0] dur;
      ev = EV_NONE;
      acc_level = lvl;
      if (!lvl) begin
         press_at   = t_at;
         hold_seen  = 1'b0;
         vlong_seen = 1'b0;
      end else begin
         release_at = t_at;
         dur = t_at - press_at;
         if (dur < {16'd0, cfg_hold}) begin
            clicks = clicks + 2'd1;
            if (clicks == DOUBLE_COUNT) begin
               clicks        = '0;
               click_waiting = 1'b0;
               ev            = EV_DOUBLE;
            end else begin
               click_waiting = 1'b1;
            end
         end
      end
      return ev;
   endfunction

   function automatic event_type classify_tick(input logic pin, input logic clr);
      logic [TIME_W-1:0] judged_at;
      logic [TIME_W-1:0] held;
      logic [TIME_W-1:0] since_release;
      event_type         ev;
      logic              decide;
      judged_at = tick_count;
      ev        = EV_NONE;
      decide    = 1'b1;
      if (clr) begin
         clicks        = '0;
         hold_seen     = 1'b0;
         vlong_seen    = 1'b0;
         click_waiting = 1'b0;
      end
      if (deb_left != '0) begin
         deb_left = deb_left - 1'b1;
         if (deb_left != '0 || pin == acc_level) begin
            decide = 1'b0;
         end else begin
            // accepted change is judged at the time of the first edge
            judged_at = change_at;
            ev = take_level(pin, judged_at);
         end
      end else if (pin != acc_level) begin
         if (cfg_debounce == '0) begin
            ev = take_level(pin, judged_at);
         end else begin
            change_at = judged_at;
            deb_left  = cfg_debounce;
            decide    = 1'b0;
         end
      end
      if (decide) begin
         if (!acc_level) begin
            held = judged_at - press_at;
            if (!vlong_seen && held >= {16'd0, cfg_vlong}) begin
               vlong_seen = 1'b1;
               hold_seen  = 1'b1;
               clicks     = '0;
               ev         = EV_VERY_LONG;
            end else if (!hold_seen && held >= {16'd0, cfg_hold}) begin
               hold_seen = 1'b1;
               clicks    = '0;
               ev        = EV_HOLD;
            end
         end
         since_release = judged_at - release_at;
         if (ev == EV_NONE && click_waiting && since_release > {16'd0, cfg_dclick}) begin
            ev            = EV_CLICK;
            click_waiting = 1'b0;
            clicks        = '0;
         end
      end
      tick_count = tick_count + 1'b1;
      return ev;
   endfunction

   function automatic int unsigned capped(input int unsigned v);
      return (v > 100) ? 100 : v;
   endfunction

   // one tick transaction, with an optional idle burst ahead of it
   task automatic send_tick(input logic pin, input logic clr);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_pin_level    <= pin;
      req_clear_events <= clr;
      do @(posedge clock); while (req_stall);
      expected_events.push_back(classify_tick(pin, clr));
      ticks_sent++;
   endtask

   task automatic send_level(input logic pin, input int unsigned n);
      repeat (n) send_tick(pin, random_clears && $urandom_range(0, 49) == 0);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input logic [DEB_W-1:0] deb, input logic [DUR_W-1:0] hold,
                             input logic [DUR_W-1:0] vlong, input logic [DUR_W-1:0] dclick);
      logic [7:0] junk;
      junk = 8'($urandom_range(0, 255));
      drain();
      // upper bits of the debounce write are don't-care
      csr_wen   <= 1'b1;
      csr_index <= CSR_DEBOUNCE;
      csr_wdata <= {junk, deb};
      @(posedge clock);
      csr_index <= CSR_HOLD;
      csr_wdata <= hold;
      @(posedge clock);
      csr_index <= CSR_VERY_LONG;
      csr_wdata <= vlong;
      @(posedge clock);
      csr_index <= CSR_DOUBLE_CLICK;
      csr_wdata <= dclick;
      @(posedge clock);
      csr_wen <= 1'b0;
      cfg_debounce = deb;
      cfg_hold     = hold;
      cfg_vlong    = vlong;
      cfg_dclick   = dclick;
      settings_used++;
   endtask

   task automatic test_reset_defaults;
      // press and release under the reset debounce, click stays pending
      send_level(1'b0, 22);
      send_level(1'b1, 22);
   endtask

   task automatic test_clear_events;
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_level(1'b0, 3);
   endtask

   task automatic test_bounce_rejected;
      set_config(8'd3, 16'd10, 16'd20, 16'd5);
      send_level(1'b1, 2);
      send_tick(1'b0, 1'b0);
      send_level(1'b1, 4);
   endtask

   task automatic test_double_click;
      send_level(1'b0, 4);
      send_level(1'b1, 4);
      send_level(1'b0, 4);
      send_level(1'b1, 6);
   endtask

   task automatic test_lone_click;
      send_level(1'b0, 4);
      send_level(1'b1, 12);
   endtask

   task automatic test_hold_and_very_long;
      send_level(1'b0, 26);
      send_level(1'b1, 5);
   endtask

   task automatic test_zero_debounce;
      set_config(8'd0, 16'd10, 16'd20, 16'd5);
      send_level(1'b0, 2);
      send_level(1'b1, 1);
      send_level(1'b0, 2);
      send_level(1'b1, 8);
      send_level(1'b0, 1);
      send_level(1'b1, 8);
   endtask

   task automatic test_threshold_floor;
      set_config(8'd0, 16'd1, 16'd1, 16'd1);
      send_level(1'b0, 3);
      send_level(1'b1, 3);
   endtask

   task automatic test_threshold_ceiling;
      set_config(8'd255, 16'hffff, 16'hffff, 16'hffff);
      send_level(1'b0, 3);
      send_level(1'b1, 2);
   endtask

   // well-formed press/release sequences with chatter, plus some noise
   task automatic run_gestures(input int unsigned n_ticks);
      int unsigned stop_at;
      int unsigned len;
      int unsigned hold_i;
      int unsigned vlong_i;
      int unsigned dclick_i;
      int unsigned deb_i;
      stop_at  = ticks_sent + n_ticks;
      hold_i   = 32'(cfg_hold);
      vlong_i  = 32'(cfg_vlong);
      dclick_i = 32'(cfg_dclick);
      deb_i    = 32'(cfg_debounce);
      while (ticks_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8))
               send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
         end else begin
            if ($urandom_range(0, 3) == 0) begin
               // contact chatter of up to the debounce time plus one tick
               repeat ($urandom_range(1, 3)) begin
                  send_level(1'b0, capped($urandom_range(1, deb_i + 1)));
                  send_level(1'b1, capped($urandom_range(1, deb_i + 1)));
               end
            end
            if ($urandom_range(0, 3) == 0)
               len = $urandom_range(hold_i, vlong_i + 4);
            else
               len = $urandom_range(1, hold_i + deb_i);
            send_level(1'b0, capped(len));
            if ($urandom_range(0, 1) == 0)
               len = $urandom_range(1, dclick_i);
            else
               len = $urandom_range(dclick_i, dclick_i + deb_i + 4);
            send_level(1'b1, capped(len));
         end
      end
   endtask

   task automatic test_random_phases;
      random_clears = 1'b1;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: set_config(8'd0, 16'd6, 16'd15, 16'd4);
            1: set_config(8'd2, 16'd12, 16'd30, 16'd8);
            2: set_config(8'd4, 16'd20, 16'd21, 16'd15);
            3: set_config(8'd1, 16'd1, 16'd3, 16'd1);
            4: set_config(8'd255, 16'hffff, 16'hffff, 16'hffff);
            default: set_config(8'($urandom_range(0, 6)), 16'($urandom_range(2, 40)),
                                16'($urandom_range(1, 80)), 16'($urandom_range(1, 40)));
         endcase
         // no idling at all in the last phase
         gaps_on = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
         run_gestures((p == 4) ? 100 : 200);
      end
      random_clears = 1'b0;
   endtask

   // result checker and rsp stall generator
   always @(posedge clock) begin : rsp_check
      event_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               errors++;
               $display("%0t: event with nothing expected, expected none, actual %0d",
                        $time, rsp_event_code);
            end else begin
               want = expected_events.pop_front();
               if (rsp_event_code !== want) begin
                  errors++;
                  $display("%0t: event mismatch, expected %0d (%s), actual %0d",
                           $time, want, want.name(), rsp_event_code);
               end
               if (rsp_event_code < 3'd5) seen_count[rsp_event_code]++;
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            rsp_stall  <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("button_gesture_classifier_tb: done, errors");
      $finish;
   end

   initial begin
      errors        = 0;
      ticks_sent    = 0;
      settings_used = 0;
      gaps_on       = 1'b1;
      random_clears = 1'b0;
      foreach (seen_count[i]) seen_count[i] = 0;
      reset_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_clear_events();
      test_bounce_rejected();
      test_double_click();
      test_lone_click();
      test_hold_and_very_long();
      test_zero_debounce();
      test_threshold_floor();
      test_threshold_ceiling();
      test_random_phases();

      drain();
      repeat (6) @(posedge clock);
      $display("summary: %0d ticks under %0d register settings, %0d errors", ticks_sent,
               settings_used, errors);
      $display("summary: none %0d, click %0d, double %0d, hold %0d, very long %0d",
               seen_count[0], seen_count[1], seen_count[2], seen_count[3], seen_count[4]);
      if (errors == 0)
         $display("button_gesture_classifier_tb: done, clean");
      else
         $display("button_gesture_classifier_tb: done, errors");
      $finish;
   end

endmodule
